// ===== rtl/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the slotted page space manager.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 32;
  localparam int DATA_BYTES   = PAGE_BYTES - HEADER_BYTES;

  localparam int LEN_W  = 12;
  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       slot_number;
    logic [LEN_W-1:0] record_length;
    logic             page_initialized;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic             status;
    logic [4:0]       result_slot;
    logic [LEN_W-1:0] region_offset;
    logic [LEN_W-1:0] region_length;
    logic [LEN_W-1:0] move_source;
    logic [LEN_W-1:0] free_bytes;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] len;
  } slot_ent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_ent_t        data;
  } mem_wr_t;

endpackage

// ===== rtl/spm_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_slot_mem
// Slot directory storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spm_slot_mem
  import spm_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] raddr,
  output slot_ent_t        rdata
);

  slot_ent_t mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/slotted_page_space_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_space_manager_unit
// Slot directory and free space bookkeeping of one page, with compaction.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_ready is high only while the unit is
// idle. An insert into a freed slot also scans the slots after it for the
// next free one. A compaction walks the slot directory through its single
// read port once per live slot placed (and once more if a free slot is left),
// with a handshake per move beat. Every beat waits for rsp_ready.
// ----------------------------------------------------------------------------
module slotted_page_space_manager_unit
  import spm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE, S_INS_RD, S_INS_CHK, S_SCAN_TEST, S_SCAN_RD, S_SCAN_EV,
    S_APP_CHK, S_APP_GAP, S_APPEND, S_REQ_RD, S_REQ_CHK, S_UPD_GROW,
    S_CMP_START, S_CMP_ROUND, S_CMP_RD, S_CMP_EV, S_CMP_PLACE, S_CMP_DONE,
    S_EMIT, S_WAIT
  } state_t;

  state_t           state, ret;
  req_t             cur;
  logic [CNT_W-1:0] slot_total, lowest_free_slot, idx, round;
  logic [LEN_W-1:0] data_start, free_space, upper, cur_len;
  logic [MAX_SLOTS-1:0] placed_marks;
  logic             best_found, cmp_upd, upd_pass;
  logic [IDX_W-1:0] best_idx;
  logic [LEN_W-1:0] best_off, best_len;
  rsp_t             ans;
  mem_wr_t          wr;
  slot_ent_t        rdata;

  localparam logic [LEN_W:0] DATA_W = (LEN_W+1)'(DATA_BYTES);
  localparam logic [LEN_W:0] SLOT_W = (LEN_W+1)'(SLOT_BYTES);

  spm_slot_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  function automatic rsp_t refuse();
    rsp_t r;
    r        = '0;
    r.status = 1'b1;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic rsp_t answer(logic [4:0] s, logic [LEN_W-1:0] o, logic [LEN_W-1:0] l);
    rsp_t r;
    r               = '0;
    r.result_slot   = s;
    r.region_offset = o;
    r.region_length = l;
    r.last          = 1'b1;
    return r;
  endfunction

  // Bytes taken by the slot table and the gap up to data_start
  logic [LEN_W:0] table_bytes, gap, need;
  logic           gap_neg, ent_live;
  assign table_bytes = (LEN_W+1)'(slot_total) * SLOT_W;
  assign gap_neg     = {1'b0, data_start} < table_bytes;
  assign gap         = {1'b0, data_start} - table_bytes;
  assign need        = {1'b0, cur.record_length} + SLOT_W;
  assign ent_live    = (rdata.off != '0) || (rdata.len != '0);

  assign req_ready = (state == S_IDLE);

  logic [LEN_W-1:0] grow, dest;
  assign grow = cur.record_length - cur_len;
  assign dest = (upper >= best_len) ? upper - best_len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ret              <= S_IDLE;
      rsp_valid        <= 1'b0;
      slot_total       <= '0;
      lowest_free_slot <= '0;
      data_start       <= '0;
      free_space       <= '0;
      placed_marks     <= '0;
      idx              <= '0;
      wr.we            <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            ret <= S_IDLE;
            unique case (req.mode)
              MODE_INSERT: begin
                if (!req.page_initialized) begin
                  if ({1'b0, req.record_length} + SLOT_W > DATA_W) begin
                    slot_total       <= '0;
                    lowest_free_slot <= '0;
                    data_start       <= LEN_W'(DATA_BYTES);
                    free_space       <= LEN_W'(DATA_BYTES);
                    ans              <= refuse();
                  end else begin
                    slot_total       <= CNT_W'(1);
                    lowest_free_slot <= CNT_W'(1);
                    data_start       <= LEN_W'(DATA_BYTES) - req.record_length;
                    free_space       <= LEN_W'(DATA_BYTES - SLOT_BYTES) - req.record_length;
                    wr.we            <= 1'b1;
                    wr.addr          <= '0;
                    wr.data          <= '{off: LEN_W'(DATA_BYTES) - req.record_length,
                                          len: req.record_length};
                    ans              <= answer('0, LEN_W'(DATA_BYTES) - req.record_length,
                                               req.record_length);
                  end
                  state <= S_EMIT;
                end else if (lowest_free_slot < slot_total) begin
                  idx   <= lowest_free_slot;
                  state <= S_INS_RD;
                end else begin
                  state <= S_APP_CHK;
                end
              end
              MODE_REMOVE: begin
                if ({2'b0, req.slot_number} >= {{(10-CNT_W){1'b0}}, slot_total}) begin
                  ans <= refuse();
                end else begin
                  wr.we   <= 1'b1;
                  wr.addr <= req.slot_number[IDX_W-1:0];
                  wr.data <= '0;
                  if (lowest_free_slot > CNT_W'(req.slot_number)) begin
                    lowest_free_slot <= CNT_W'(req.slot_number);
                  end
                  ans <= answer(5'(req.slot_number), '0, '0);
                end
                state <= S_EMIT;
              end
              default: begin
                if ({2'b0, req.slot_number} >= {{(10-CNT_W){1'b0}}, slot_total}) begin
                  ans   <= refuse();
                  state <= S_EMIT;
                end else begin
                  idx   <= CNT_W'(req.slot_number);
                  state <= S_REQ_RD;
                end
              end
            endcase
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          if (cur.record_length <= rdata.len) begin
            free_space       <= free_space + (rdata.len - cur.record_length);
            wr.we            <= 1'b1;
            wr.addr          <= idx[IDX_W-1:0];
            wr.data          <= '{off: rdata.off, len: cur.record_length};
            ans              <= answer(5'(idx), rdata.off, cur.record_length);
            lowest_free_slot <= slot_total;
            idx              <= idx + 1'b1;
            state            <= S_SCAN_TEST;
          end else begin
            state <= S_APP_CHK;
          end
        end
        S_SCAN_TEST: begin
          wr.we <= 1'b0;
          state <= (idx >= slot_total) ? S_EMIT : S_SCAN_RD;
        end
        S_SCAN_RD:   state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (!ent_live) begin
            lowest_free_slot <= idx;
            state            <= S_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_TEST;
          end
        end
        S_APP_CHK: begin
          if (slot_total >= CNT_W'(MAX_SLOTS) || {1'b0, free_space} < need) begin
            ans   <= refuse();
            state <= S_EMIT;
          end else if (gap_neg || gap < need) begin
            cmp_upd <= 1'b0;
            state   <= S_CMP_START;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APP_GAP: begin
          if (gap_neg || gap < need) begin
            ans   <= refuse();
            state <= S_EMIT;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          slot_total <= slot_total + 1'b1;
          data_start <= data_start - cur.record_length;
          free_space <= free_space - LEN_W'(need);
          if (lowest_free_slot == slot_total) begin
            lowest_free_slot <= lowest_free_slot + 1'b1;
          end
          wr.we   <= 1'b1;
          wr.addr <= slot_total[IDX_W-1:0];
          wr.data <= '{off: data_start - cur.record_length, len: cur.record_length};
          ans     <= answer(5'(slot_total), data_start - cur.record_length,
                            cur.record_length);
          state   <= S_EMIT;
        end
        S_REQ_RD: state <= S_REQ_CHK;
        S_REQ_CHK: begin
          cur_len <= rdata.len;
          if (!ent_live) begin
            ans   <= refuse();
            state <= S_EMIT;
          end else if (cur.mode == MODE_LOOKUP) begin
            ans   <= answer(5'(idx), rdata.off, rdata.len);
            state <= S_EMIT;
          end else if (cur.record_length <= rdata.len) begin
            free_space <= free_space + (rdata.len - cur.record_length);
            wr.we      <= 1'b1;
            wr.addr    <= idx[IDX_W-1:0];
            wr.data    <= '{off: rdata.off, len: cur.record_length};
            ans        <= answer(5'(idx), rdata.off, cur.record_length);
            state      <= S_EMIT;
          end else begin
            upd_pass <= 1'b0;
            state    <= S_UPD_GROW;
          end
        end
        S_UPD_GROW: begin
          if (gap_neg) begin
            ans   <= refuse();
            state <= S_EMIT;
          end else if (gap >= {1'b0, cur.record_length}) begin
            free_space <= (free_space >= grow) ? free_space - grow : '0;
            data_start <= data_start - cur.record_length;
            wr.we      <= 1'b1;
            wr.addr    <= cur.slot_number[IDX_W-1:0];
            wr.data    <= '{off: data_start - cur.record_length, len: cur.record_length};
            ans        <= answer(5'(cur.slot_number), data_start - cur.record_length,
                                 cur.record_length);
            state      <= S_EMIT;
          end else if (!upd_pass) begin
            upd_pass <= 1'b1;
            cmp_upd  <= 1'b1;
            state    <= S_CMP_START;
          end else begin
            ans   <= refuse();
            state <= S_EMIT;
          end
        end
        S_CMP_START: begin
          placed_marks <= '0;
          upper        <= LEN_W'(DATA_BYTES);
          round        <= '0;
          state        <= S_CMP_ROUND;
        end
        S_CMP_ROUND: begin
          best_found <= 1'b0;
          idx        <= '0;
          state      <= (round >= slot_total) ? S_CMP_DONE : S_CMP_RD;
        end
        S_CMP_RD: state <= S_CMP_EV;
        S_CMP_EV: begin
          // Highest old offset wins; strict compare keeps the lower slot on ties
          if (!placed_marks[idx[IDX_W-1:0]] && ent_live &&
              (!best_found || rdata.off > best_off)) begin
            best_found <= 1'b1;
            best_idx   <= idx[IDX_W-1:0];
            best_off   <= rdata.off;
            best_len   <= rdata.len;
          end
          if (idx == slot_total - 1'b1) begin
            state <= S_CMP_PLACE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_CMP_PLACE: begin
          if (!best_found) begin
            state <= S_CMP_DONE;
          end else begin
            placed_marks[best_idx] <= 1'b1;
            wr.we   <= 1'b1;
            wr.addr <= best_idx;
            wr.data <= '{off: dest, len: best_len};
            ans     <= '{kind: 1'b1, status: 1'b0, result_slot: 5'(best_idx),
                         region_offset: dest, region_length: best_len,
                         move_source: best_off, free_bytes: '0, last: 1'b0};
            upper   <= dest;
            round   <= round + 1'b1;
            ret     <= S_CMP_ROUND;
            state   <= S_EMIT;
          end
        end
        S_CMP_DONE: begin
          data_start <= upper;
          ret        <= S_IDLE;
          state      <= cmp_upd ? S_UPD_GROW : S_APP_GAP;
        end
        S_EMIT: begin
          wr.we     <= 1'b0;
          rsp       <= '{kind: ans.kind, status: ans.status, result_slot: ans.result_slot,
                         region_offset: ans.region_offset, region_length: ans.region_length,
                         move_source: ans.move_source, free_bytes: free_space,
                         last: ans.last};
          rsp_valid <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> !rsp_valid)
    else $error("request taken while a beat is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && rsp.last) |=> (state == S_IDLE))
    else $error("final beat did not return to idle");

  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.kind) |-> !rsp.last)
    else $error("move beat marked last");

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    (slot_total <= CNT_W'(MAX_SLOTS)) && (lowest_free_slot <= slot_total))
    else $error("slot table bookkeeping out of range");

endmodule

// ===== tb/sv/tb_slotted_page_space_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slotted_page_space_manager_unit
// Drives insert, remove, lookup and update requests into the page space
// manager, predicts every answer and compaction move beat with a behavioral
// model of the slot directory, and checks each response beat in order.
// ----------------------------------------------------------------------------
module tb_slotted_page_space_manager_unit;
  import spm_pkg::*;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  slotted_page_space_manager_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // page model
  logic [LEN_W-1:0] pg_off [MAX_SLOTS];
  logic [LEN_W-1:0] pg_len [MAX_SLOTS];
  logic             pg_placed [MAX_SLOTS];
  int unsigned      pg_total;
  int unsigned      pg_low_free;
  int unsigned      pg_start;
  int unsigned      pg_free;

  rsp_t expected_beats [$];
  int   errors;
  int   send_idle_pct;
  int   stall_pct;
  bit   hold_off;
  bit   stim_done;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit slot_live(int unsigned i);
    return pg_off[i] != '0 || pg_len[i] != '0;
  endfunction

  function automatic int table_gap();
    return int'(pg_start) - int'(SLOT_BYTES * pg_total);
  endfunction

  function automatic void push_beat(bit k, bit st, int unsigned s, int unsigned off,
                                    int unsigned len, int unsigned src, bit lst);
    rsp_t r;
    r.kind          = k;
    r.status        = st;
    r.result_slot   = s[4:0];
    r.region_offset = off[LEN_W-1:0];
    r.region_length = len[LEN_W-1:0];
    r.move_source   = src[LEN_W-1:0];
    r.free_bytes    = pg_free[LEN_W-1:0];
    r.last          = lst;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  function automatic void push_refusal();
    push_beat(1'b0, 1'b1, 0, 0, 0, 0, 1'b1);
  endfunction

  function automatic void compact_page();
    int unsigned upper;
    int best;
    int unsigned dest;
    upper = DATA_BYTES;
    for (int i = 0; i < MAX_SLOTS; i++) pg_placed[i] = 1'b0;
    for (int r = 0; r < pg_total; r++) begin
      best = -1;
      for (int i = 0; i < pg_total; i++) begin
        if (!pg_placed[i] && slot_live(i) && (best < 0 || pg_off[i] > pg_off[best]))
          best = i;
      end
      if (best < 0) break;
      pg_placed[best] = 1'b1;
      dest = (upper >= pg_len[best]) ? upper - pg_len[best] : 0;
      push_beat(1'b1, 1'b0, best, dest, pg_len[best], pg_off[best], 1'b0);
      pg_off[best] = LEN_W'(dest);
      upper = dest;
    end
    pg_start = upper;
  endfunction

  function automatic void predict_insert(int unsigned len, bit init);
    int unsigned s;
    if (!init) begin
      if (len + SLOT_BYTES > DATA_BYTES) begin
        pg_total = 0; pg_low_free = 0; pg_start = DATA_BYTES; pg_free = DATA_BYTES;
        push_refusal();
        return;
      end
      pg_total = 1; pg_low_free = 1;
      pg_start = DATA_BYTES - len;
      pg_free = DATA_BYTES - SLOT_BYTES - len;
      pg_off[0] = LEN_W'(pg_start); pg_len[0] = LEN_W'(len);
      push_beat(1'b0, 1'b0, 0, pg_start, len, 0, 1'b1);
      return;
    end
    if (pg_low_free < pg_total && len <= pg_len[pg_low_free]) begin
      s = pg_low_free;
      pg_free += pg_len[s] - len;
      pg_len[s] = LEN_W'(len);
      pg_low_free = pg_total;
      for (int unsigned i = s + 1; i < pg_total; i++) begin
        if (!slot_live(i)) begin
          pg_low_free = i;
          break;
        end
      end
      push_beat(1'b0, 1'b0, s, pg_off[s], len, 0, 1'b1);
      return;
    end
    if (pg_total >= MAX_SLOTS || pg_free < len + SLOT_BYTES) begin
      push_refusal();
      return;
    end
    if (table_gap() < int'(len + SLOT_BYTES)) begin
      compact_page();
      if (table_gap() < int'(len + SLOT_BYTES)) begin
        push_refusal();
        return;
      end
    end
    pg_total++;
    pg_start -= len;
    pg_free -= SLOT_BYTES + len;
    if (pg_low_free == pg_total - 1) pg_low_free++;
    pg_off[pg_total-1] = LEN_W'(pg_start);
    pg_len[pg_total-1] = LEN_W'(len);
    push_beat(1'b0, 1'b0, pg_total - 1, pg_start, len, 0, 1'b1);
  endfunction

  function automatic void predict_update(int unsigned s, int unsigned len);
    int g;
    int unsigned grow;
    if (s >= pg_total || !slot_live(s)) begin
      push_refusal();
      return;
    end
    if (len <= pg_len[s]) begin
      pg_free += pg_len[s] - len;
      pg_len[s] = LEN_W'(len);
      push_beat(1'b0, 1'b0, s, pg_off[s], len, 0, 1'b1);
      return;
    end
    for (int p = 0; p < 2; p++) begin
      g = table_gap();
      if (g < 0) break;
      if (g >= int'(len)) begin
        grow = len - pg_len[s];
        pg_free = (pg_free >= grow) ? pg_free - grow : 0;
        pg_off[s] = LEN_W'(pg_start - len);
        pg_len[s] = LEN_W'(len);
        pg_start = pg_off[s];
        push_beat(1'b0, 1'b0, s, pg_off[s], len, 0, 1'b1);
        return;
      end
      if (p == 0) compact_page();
    end
    push_refusal();
  endfunction

  function automatic void predict_request(req_t r);
    int unsigned s;
    s = r.slot_number;
    case (r.mode)
      MODE_INSERT: predict_insert(r.record_length, r.page_initialized);
      MODE_REMOVE: begin
        if (s >= pg_total) begin
          push_refusal();
        end else begin
          pg_off[s] = '0; pg_len[s] = '0;
          if (pg_low_free > s) pg_low_free = s;
          push_beat(1'b0, 1'b0, s, 0, 0, 0, 1'b1);
        end
      end
      MODE_LOOKUP: begin
        if (s >= pg_total || !slot_live(s)) push_refusal();
        else push_beat(1'b0, 1'b0, s, pg_off[s], pg_len[s], 0, 1'b1);
      end
      default: predict_update(s, r.record_length);
    endcase
  endfunction

  // one request beat; valid holds until accepted, and stays up into the
  // next beat unless the sender idles
  task automatic send_request(mode_t m, int unsigned s, int unsigned len, bit init);
    req_t r;
    r.mode = m;
    r.slot_number = s[7:0];
    r.record_length = len[LEN_W-1:0];
    r.page_initialized = init;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
      if (rsp_valid && rsp_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, rsp);
          errors++;
        end else begin
          rsp_t e;
          e = expected_beats.pop_front();
          if (rsp.kind !== e.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, e.kind, rsp.kind); errors++;
          end
          if (rsp.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status); errors++;
          end
          if (rsp.result_slot !== e.result_slot) begin
            $display("%0t: slot exp %0d got %0d", $time, e.result_slot, rsp.result_slot);
            errors++;
          end
          if (rsp.region_offset !== e.region_offset) begin
            $display("%0t: offset exp %0d got %0d", $time, e.region_offset,
                     rsp.region_offset);
            errors++;
          end
          if (rsp.region_length !== e.region_length) begin
            $display("%0t: length exp %0d got %0d", $time, e.region_length,
                     rsp.region_length);
            errors++;
          end
          if (rsp.move_source !== e.move_source) begin
            $display("%0t: source exp %0d got %0d", $time, e.move_source, rsp.move_source);
            errors++;
          end
          if (rsp.free_bytes !== e.free_bytes) begin
            $display("%0t: free exp %0d got %0d", $time, e.free_bytes, rsp.free_bytes);
            errors++;
          end
          if (rsp.last !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, rsp.last); errors++;
          end
        end
      end
    end
  end

  // long receiver hold-off, counted in its own process
  task automatic hold_receiver(int n);
    hold_off <= 1'b1;
    repeat (n) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 10000000) begin
      $display("tb_slotted_page_space_manager_unit: FAIL");
      $finish;
    end
  end

  function automatic int unsigned rand_len();
    case ($urandom_range(9))
      0: return $urandom_range(4095);
      1: return 0;
      2: return $urandom_range(1500, 4095);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // slot numbers below total most of the time; one in ten is any
  // value up to 255, and an empty page draws from 0 to 3
  function automatic int unsigned rand_slot();
    if ($urandom_range(9) == 0) return $urandom_range(255);
    if (pg_total == 0) return $urandom_range(3);
    return $urandom_range(pg_total - 1);
  endfunction

  task automatic test_directed();
    send_request(MODE_INSERT, 0, 4095, 1'b0);   // header rebuild too large
    send_request(MODE_INSERT, 0, 100, 1'b0);
    send_request(MODE_INSERT, 0, 0, 1'b1);
    send_request(MODE_INSERT, 0, 200, 1'b1);
    send_request(MODE_LOOKUP, 1, 0, 1'b0);
    send_request(MODE_LOOKUP, 255, 0, 1'b0);    // bad slot
    send_request(MODE_REMOVE, 1, 0, 1'b0);
    send_request(MODE_LOOKUP, 1, 0, 1'b0);      // free slot
    send_request(MODE_UPDATE, 1, 5, 1'b0);      // free slot
    send_request(MODE_INSERT, 0, 500, 1'b1);    // freed slot too small
    send_request(MODE_REMOVE, 2, 0, 1'b0);
    send_request(MODE_UPDATE, 2, 9, 1'b0);
    send_request(MODE_UPDATE, 0, 50, 1'b0);     // shrink
    send_request(MODE_UPDATE, 0, 3000, 1'b0);   // growth into the gap, without compaction
    send_request(MODE_INSERT, 0, 3500, 1'b1);   // no room
    send_request(MODE_REMOVE, 255, 0, 1'b0);
    send_request(MODE_INSERT, 0, 4092, 1'b0);   // too large for a fresh page
    send_request(MODE_INSERT, 0, 1, 1'b1);
    send_request(MODE_INSERT, 0, 10, 1'b0);
    for (int i = 0; i < 33; i++) send_request(MODE_INSERT, 0, 3, 1'b1);  // table full
    send_request(MODE_UPDATE, 31, 2000, 1'b0);
    drain();
  endtask

  task automatic test_random(int n);
    int unsigned m;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(99);
      if (m < 4) send_request(MODE_INSERT, $urandom_range(255), rand_len(), 1'b0);
      else if (m < 45) send_request(MODE_INSERT, $urandom_range(255), rand_len(), 1'b1);
      else if (m < 65) send_request(MODE_REMOVE, rand_slot(), $urandom_range(4095), 1'b0);
      else if (m < 78)
        send_request(MODE_LOOKUP, rand_slot(), $urandom_range(4095), $urandom_range(1));
      else send_request(MODE_UPDATE, rand_slot(), rand_len(), $urandom_range(1));
    end
  endtask

  task automatic test_pressure();
    fork
      hold_receiver(3000);
      begin
        send_idle_pct = 0;
        test_random(20);
      end
    join
    drain();
    send_request(MODE_LOOKUP, 0, 0, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      pg_off[i] = '0; pg_len[i] = '0; pg_placed[i] = 1'b0;
    end
    pg_total = 0; pg_low_free = 0; pg_start = 0; pg_free = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(100);
    send_idle_pct = 77; stall_pct = 0;  test_random(90);
    send_idle_pct = 0;  stall_pct = 77; test_random(90);
    send_idle_pct = 21; stall_pct = 21; test_random(90);
    test_pressure();
    send_idle_pct = 0;  stall_pct = 0;  test_random(40);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("tb_slotted_page_space_manager_unit: PASS");
    end else begin
      $display("tb_slotted_page_space_manager_unit: FAIL");
    end
    $finish;
  end

endmodule
